// File: sv/apws_pkg.sv
`timescale 1ns / 1ps
package apws_pkg;
	localparam int MAX_VERTICES = 256;
	localparam int MAX_EDGES    = 1024;
	localparam int SLOTS        = 2 * MAX_EDGES;
	localparam int VBITS        = $clog2(MAX_VERTICES);
	localparam int CNT_BITS     = VBITS + 1;
	localparam int SLOT_BITS    = $clog2(SLOTS);
	localparam int LINK_BITS    = SLOT_BITS + 1;
	localparam int WEIGHT_BITS  = 32;
	localparam int SUM_BITS     = 40;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_EDGE = 2'd1;
	localparam logic [1:0] FUNC_RUN  = 2'd2;

	typedef enum logic [1:0] {OP_LOAD, OP_EDGE, OP_RUN} op_t;

	typedef struct packed {
		op_t                     op;
		logic [7:0]              a;
		logic [7:0]              b;
		logic signed [31:0]      weight;
	} item_t;

	typedef struct packed {
		logic  push;
		item_t item;
	} q_wr_t;
endpackage

// File: sv/articulation_point_weight_sum.sv
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// in       in_valid / in_ready    func, vertex_a, vertex_b, weight
// out      out_valid / out_ready  weight_sum, is_positive, cut_count, edge_overflow
// cfg      cfg_we                 cfg_wdata (vertex_count)
//
// A weight load is written straight from the queue while the engine idles; an
// edge add reads both list heads, then writes the two half edges in turn on
// the single edge memory write port. A run's length grows with the edge
// halves visited, vertices reached and vertex_count, set by the registered
// reads of edge, stack and weight memories and any held result's wait on out_ready.
// A two entry queue keeps input flowing while the engine works or the result
// waits. Reset clears all control state and empties every adjacency list.
module articulation_point_weight_sum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [apws_pkg::CNT_BITS-1:0]       cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          func,
	input  logic [7:0]                          vertex_a,
	input  logic [7:0]                          vertex_b,
	input  logic signed [31:0]                  weight,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [apws_pkg::SUM_BITS-1:0] weight_sum,
	output logic                                is_positive,
	output logic [apws_pkg::CNT_BITS-1:0]       cut_count,
	output logic                                edge_overflow
);
	import apws_pkg::*;

	logic [CNT_BITS-1:0] vertex_count_q;
	logic [CNT_BITS-1:0] n_eff;
	q_wr_t               q_wr;
	logic                q_full, rd_valid, rd_pop;
	item_t               rd_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vertex_count_q <= CNT_BITS'(MAX_VERTICES);
		else if (cfg_we) vertex_count_q <= cfg_wdata;
	end

	always_comb begin
		n_eff = vertex_count_q;
		if (n_eff == '0) n_eff = CNT_BITS'(1);
		if (n_eff > CNT_BITS'(MAX_VERTICES)) n_eff = CNT_BITS'(MAX_VERTICES);
	end

	apws_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.vertex_a (vertex_a),
		.vertex_b (vertex_b),
		.weight   (weight),
		.q_full   (q_full),
		.q_wr     (q_wr)
	);

	apws_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.full     (q_full),
		.rd_valid (rd_valid),
		.rd_item  (rd_item),
		.rd_pop   (rd_pop)
	);

	apws_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.n_eff         (n_eff),
		.rd_valid      (rd_valid),
		.rd_item       (rd_item),
		.rd_pop        (rd_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.weight_sum    (weight_sum),
		.is_positive   (is_positive),
		.cut_count     (cut_count),
		.edge_overflow (edge_overflow)
	);
endmodule

// File: sv/apws_front.sv
`timescale 1ns / 1ps
module apws_front (
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          func,
	input  logic [7:0]          vertex_a,
	input  logic [7:0]          vertex_b,
	input  logic signed [31:0]  weight,
	input  logic                q_full,
	output apws_pkg::q_wr_t     q_wr
);
	import apws_pkg::*;

	logic  known;
	op_t   op;

	always_comb begin
		known = 1'b1;
		op = OP_LOAD;
		case (func)
			FUNC_LOAD: op = OP_LOAD;
			FUNC_EDGE: op = OP_EDGE;
			FUNC_RUN:  op = OP_RUN;
			default:   known = 1'b0;
		endcase
	end

	assign in_ready = !q_full;

	// Unused function codes are accepted and dropped here.
	always_comb begin
		q_wr.push = in_valid && !q_full && known;
		q_wr.item.op = op;
		q_wr.item.a = vertex_a;
		q_wr.item.b = vertex_b;
		q_wr.item.weight = weight;
	end
endmodule

// File: sv/apws_queue.sv
`timescale 1ns / 1ps
module apws_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  apws_pkg::q_wr_t   wr,
	output logic              full,
	output logic              rd_valid,
	output apws_pkg::item_t   rd_item,
	input  logic              rd_pop
);
	import apws_pkg::*;

	item_t       slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr.push) wr_ptr_q <= !wr_ptr_q;
			if (rd_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, wr.push} - {1'b0, rd_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (wr.push) slot_q[wr_ptr_q] <= wr.item;
	end
endmodule

// File: sv/apws_engine.sv
`timescale 1ns / 1ps
module apws_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [apws_pkg::CNT_BITS-1:0]       n_eff,
	input  logic                                rd_valid,
	input  apws_pkg::item_t                     rd_item,
	output logic                                rd_pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [apws_pkg::SUM_BITS-1:0] weight_sum,
	output logic                                is_positive,
	output logic [apws_pkg::CNT_BITS-1:0]       cut_count,
	output logic                                edge_overflow
);
	import apws_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_EDGE1  = 4'd1;
	localparam logic [3:0] ST_EDGE2  = 4'd2;
	localparam logic [3:0] ST_INIT   = 4'd3;
	localparam logic [3:0] ST_STEP   = 4'd4;
	localparam logic [3:0] ST_EDGE_RD = 4'd5;
	localparam logic [3:0] ST_BACK   = 4'd6;
	localparam logic [3:0] ST_PUSH   = 4'd7;
	localparam logic [3:0] ST_POP    = 4'd8;
	localparam logic [3:0] ST_POP2   = 4'd9;
	localparam logic [3:0] ST_SUM    = 4'd10;
	localparam logic [3:0] ST_SUM_LAST = 4'd11;
	localparam logic [3:0] ST_DONE   = 4'd12;

	typedef struct packed {
		logic [VBITS-1:0]     vtx;
		logic [VBITS-1:0]     par;
		logic [LINK_BITS-1:0] link;
		logic [VBITS-1:0]     disc;
		logic [VBITS-1:0]     low;
	} entry_t;

	typedef struct packed {
		logic [VBITS-1:0]     tgt;
		logic [LINK_BITS-1:0] nxt;
	} edge_t;

	logic [WEIGHT_BITS-1:0] weight_mem [MAX_VERTICES];
	logic [LINK_BITS-1:0]   head_mem   [MAX_VERTICES];
	edge_t                  edge_mem   [SLOTS];
	logic [VBITS-1:0]       disc_mem   [MAX_VERTICES];
	entry_t                 stack_mem  [MAX_VERTICES];

	logic [3:0]             state_q;
	logic [LINK_BITS-1:0]   fill_q;
	logic                   ovf_q;
	logic [VBITS-1:0]       ea_q, eb_q;
	logic [MAX_VERTICES-1:0] head_valid_q, visited_q, cut_q;

	logic [LINK_BITS-1:0]   head_rd0_q, head_rd1_q;
	logic                   head_hv0_q, head_hv1_q;
	edge_t                  edge_rd_q;
	logic [VBITS-1:0]       disc_rd_q;
	entry_t                 stack_rd_q;
	logic [WEIGHT_BITS-1:0] wt_rd_q;

	logic [VBITS-1:0]       u_q, par_q, disc_u_q, low_u_q, child_low_q;
	logic [LINK_BITS-1:0]   link_q;
	logic [CNT_BITS-1:0]    depth_q, time_q, sum_idx_q;
	logic [1:0]             root_kids_q;
	logic                   sum_vld_s1, sum_cut_s1;
	logic signed [SUM_BITS-1:0] sum_q;
	logic [CNT_BITS-1:0]    cnt_q;

	logic                   out_valid_q, pos_q, ovf_out_q;
	logic signed [SUM_BITS-1:0] sum_out_q;
	logic [CNT_BITS-1:0]    cnt_out_q;

	logic [LINK_BITS-1:0]   head0, head1;
	logic [VBITS-1:0]       head_ra0, head_ra1;
	logic                   head_we;
	logic [VBITS-1:0]       head_waddr;
	logic [LINK_BITS-1:0]   head_wdata;
	logic                   edge_we;
	logic [SLOT_BITS-1:0]   edge_waddr, edge_raddr;
	edge_t                  edge_wdata;
	logic                   stk_we;
	entry_t                 stk_wdata;
	logic [VBITS-1:0]       stk_waddr, stk_raddr;
	logic                   can_push, w_skip, w_tree_parent;
	logic [VBITS-1:0]       w;
	logic                   edge_bad;
	logic [LINK_BITS:0]     fill_plus2;
	logic [LINK_BITS-1:0]   fill_p1, fill_p2;
	logic                   out_free;

	assign head0 = head_hv0_q ? head_rd0_q : '0;
	assign head1 = head_hv1_q ? head_rd1_q : '0;
	assign w = edge_rd_q.tgt;
	assign w_skip = ({1'b0, w} >= n_eff);
	assign w_tree_parent = (depth_q > CNT_BITS'(1)) && (par_q == w);
	assign can_push = (depth_q < n_eff);
	assign fill_plus2 = {1'b0, fill_q} + (LINK_BITS + 1)'(2);
	assign fill_p1 = fill_q + LINK_BITS'(1);
	assign fill_p2 = fill_q + LINK_BITS'(2);
	assign edge_bad = ({1'b0, rd_item.a} >= n_eff) || ({1'b0, rd_item.b} >= n_eff)
		|| (fill_plus2 > (LINK_BITS + 1)'(SLOTS));
	assign out_free = !out_valid_q || out_ready;
	assign rd_pop = (state_q == ST_IDLE) && rd_valid;

	// Memory strobes follow the state register directly.
	always_comb begin
		head_ra0 = (rd_item.op == OP_RUN) ? '0 : rd_item.a;
		head_ra1 = (state_q == ST_IDLE) ? rd_item.b : eb_q;
		if (state_q != ST_IDLE) head_ra0 = w;
		head_we = 1'b0;
		head_waddr = ea_q;
		head_wdata = fill_p1;
		edge_we = 1'b0;
		edge_waddr = fill_q[SLOT_BITS-1:0];
		edge_wdata.tgt = eb_q;
		edge_wdata.nxt = head0;
		edge_raddr = SLOT_BITS'(link_q - LINK_BITS'(1));
		stk_we = 1'b0;
		stk_waddr = VBITS'(depth_q - CNT_BITS'(1));
		stk_raddr = VBITS'(depth_q - CNT_BITS'(2));
		stk_wdata.vtx = u_q;
		stk_wdata.par = par_q;
		stk_wdata.link = edge_rd_q.nxt;
		stk_wdata.disc = disc_u_q;
		stk_wdata.low = low_u_q;
		case (state_q)
			ST_EDGE1: begin
				head_we = 1'b1;
				edge_we = 1'b1;
			end
			ST_EDGE2: begin
				head_we = 1'b1;
				head_waddr = eb_q;
				head_wdata = fill_p2;
				edge_we = 1'b1;
				edge_waddr = fill_p1[SLOT_BITS-1:0];
				edge_wdata.tgt = ea_q;
				// A self loop must link to the half written in ST_EDGE1.
				edge_wdata.nxt = (ea_q == eb_q) ? fill_p1 : head1;
			end
			ST_EDGE_RD: begin
				stk_we = !w_skip && !visited_q[w] && can_push;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_pop && rd_item.op == OP_LOAD)
			weight_mem[rd_item.a] <= WEIGHT_BITS'(rd_item.weight);
		wt_rd_q <= weight_mem[sum_idx_q[VBITS-1:0]];
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_waddr] <= head_wdata;
		head_rd0_q <= head_mem[head_ra0];
		head_rd1_q <= head_mem[head_ra1];
	end

	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
		edge_rd_q <= edge_mem[edge_raddr];
	end

	// The root is never pushed, so its discovery time is set when a run starts.
	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) disc_mem[VBITS'(0)] <= '0;
		else if (stk_we) disc_mem[w] <= time_q[VBITS-1:0];
		disc_rd_q <= disc_mem[w];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
		stack_rd_q <= stack_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			ovf_q <= 1'b0;
			head_valid_q <= '0;
			head_hv0_q <= 1'b0;
			head_hv1_q <= 1'b0;
			visited_q <= '0;
			cut_q <= '0;
			depth_q <= '0;
			time_q <= '0;
			root_kids_q <= '0;
			sum_vld_s1 <= 1'b0;
			sum_cut_s1 <= 1'b0;
			sum_idx_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			ea_q <= '0;
			eb_q <= '0;
			u_q <= '0;
			par_q <= '0;
			link_q <= '0;
			disc_u_q <= '0;
			low_u_q <= '0;
			child_low_q <= '0;
		end else begin
			head_hv0_q <= head_valid_q[head_ra0];
			head_hv1_q <= head_valid_q[head_ra1];
			sum_vld_s1 <= (state_q == ST_SUM);
			sum_cut_s1 <= cut_q[sum_idx_q[VBITS-1:0]];
			if (sum_vld_s1 && sum_cut_s1) begin
				sum_q <= sum_q + SUM_BITS'(signed'(wt_rd_q));
				cnt_q <= cnt_q + CNT_BITS'(1);
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (rd_valid) begin
						case (rd_item.op)
							OP_EDGE: begin
								ea_q <= rd_item.a;
								eb_q <= rd_item.b;
								if (edge_bad) ovf_q <= 1'b1;
								else state_q <= ST_EDGE1;
							end
							OP_RUN: state_q <= ST_INIT;
							default: ;
						endcase
					end
				end
				ST_EDGE1: begin
					head_valid_q[ea_q] <= 1'b1;
					state_q <= ST_EDGE2;
				end
				ST_EDGE2: begin
					head_valid_q[eb_q] <= 1'b1;
					fill_q <= fill_p2;
					state_q <= ST_IDLE;
				end
				ST_INIT: begin
					visited_q <= MAX_VERTICES'(1);
					cut_q <= '0;
					u_q <= '0;
					par_q <= '0;
					link_q <= head0;
					disc_u_q <= '0;
					low_u_q <= '0;
					time_q <= CNT_BITS'(1);
					depth_q <= CNT_BITS'(1);
					root_kids_q <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (link_q != '0 && link_q <= LINK_BITS'(SLOTS)) state_q <= ST_EDGE_RD;
					else state_q <= ST_POP;
				end
				ST_EDGE_RD: begin
					link_q <= edge_rd_q.nxt;
					state_q <= ST_STEP;
					if (!w_skip) begin
						if (visited_q[w]) begin
							if (!w_tree_parent) state_q <= ST_BACK;
						end else if (can_push) begin
							if (depth_q == CNT_BITS'(1) && root_kids_q != 2'd2)
								root_kids_q <= root_kids_q + 2'd1;
							visited_q[w] <= 1'b1;
							u_q <= w;
							par_q <= u_q;
							disc_u_q <= time_q[VBITS-1:0];
							low_u_q <= time_q[VBITS-1:0];
							time_q <= time_q + CNT_BITS'(1);
							depth_q <= depth_q + CNT_BITS'(1);
							state_q <= ST_PUSH;
						end
					end
				end
				ST_BACK: begin
					if (disc_rd_q < low_u_q) low_u_q <= disc_rd_q;
					state_q <= ST_STEP;
				end
				ST_PUSH: begin
					link_q <= head0;
					state_q <= ST_STEP;
				end
				ST_POP: begin
					depth_q <= depth_q - CNT_BITS'(1);
					child_low_q <= low_u_q;
					if (depth_q == CNT_BITS'(1)) begin
						if (root_kids_q == 2'd2) cut_q[u_q] <= 1'b1;
						sum_idx_q <= '0;
						sum_q <= '0;
						cnt_q <= '0;
						state_q <= ST_SUM;
					end else begin
						state_q <= ST_POP2;
					end
				end
				ST_POP2: begin
					u_q <= stack_rd_q.vtx;
					par_q <= stack_rd_q.par;
					link_q <= stack_rd_q.link;
					disc_u_q <= stack_rd_q.disc;
					low_u_q <= (child_low_q < stack_rd_q.low) ? child_low_q : stack_rd_q.low;
					if (depth_q > CNT_BITS'(1) && child_low_q >= stack_rd_q.disc)
						cut_q[stack_rd_q.vtx] <= 1'b1;
					state_q <= ST_STEP;
				end
				ST_SUM: begin
					sum_idx_q <= sum_idx_q + CNT_BITS'(1);
					if (sum_idx_q == n_eff - CNT_BITS'(1)) state_q <= ST_SUM_LAST;
				end
				ST_SUM_LAST: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			sum_out_q <= sum_q;
			pos_q <= !sum_q[SUM_BITS-1] && (sum_q != '0);
			cnt_out_q <= cnt_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign weight_sum = sum_out_q;
	assign is_positive = pos_q;
	assign cut_count = cnt_out_q;
	assign edge_overflow = ovf_out_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= n_eff) else $error("stack depth beyond vertex count");
	a_sum_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM |-> depth_q == '0) else $error("summing with a live stack");
	a_fill_even: assert property (@(posedge clk) disable iff (!arst_n)
		!fill_q[0] && fill_q <= LINK_BITS'(SLOTS)) else $error("edge fill out of shape");
	a_top_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> visited_q[u_q]) else $error("stack top not visited");
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import apws_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int STALL_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic signed [SUM_BITS-1:0] sum;
		logic                       positive;
		logic [CNT_BITS-1:0]        count;
		logic                       overflow;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CNT_BITS-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = '0;
	logic [7:0] vertex_a = '0;
	logic [7:0] vertex_b = '0;
	logic signed [31:0] weight = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SUM_BITS-1:0] weight_sum;
	logic is_positive;
	logic [CNT_BITS-1:0] cut_count;
	logic edge_overflow;

	// Shadow copy of the graph store.
	logic signed [31:0] vert_weight [MAX_VERTICES];
	int adj_head [MAX_VERTICES];
	int slot_target [SLOTS];
	int slot_next [SLOTS];
	int slots_used;
	bit dropped_edge;
	logic [CNT_BITS-1:0] vcount_reg;

	report_t pending_reports[$];
	int mismatches, reports_seen, items_sent, edges_sent, runs_sent;
	int idle_pct, stall_pct, quiet_cycles;

	always #6 clk = ~clk;

	articulation_point_weight_sum dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.vertex_a(vertex_a), .vertex_b(vertex_b), .weight(weight),
		.out_valid(out_valid), .out_ready(out_ready), .weight_sum(weight_sum),
		.is_positive(is_positive), .cut_count(cut_count),
		.edge_overflow(edge_overflow)
	);

	function automatic int live_vertices();
		int n;
		n = vcount_reg;
		if (n < 1) n = 1;
		if (n > MAX_VERTICES) n = MAX_VERTICES;
		return n;
	endfunction

	function automatic void link_slot(int from, int to);
		slot_target[slots_used] = to;
		slot_next[slots_used] = adj_head[from];
		adj_head[from] = slots_used + 1;
		slots_used++;
	endfunction

	// Iterative depth-first search that returns the cut-vertex report.
	function automatic report_t predict_cut_report();
		int n, sp, clock_t, u, lnk, w, p;
		int disc [MAX_VERTICES];
		int lowt [MAX_VERTICES];
		bit seen [MAX_VERTICES];
		bit has_parent [MAX_VERTICES];
		int parent [MAX_VERTICES];
		bit cut [MAX_VERTICES];
		int stk_v [MAX_VERTICES];
		int stk_c [MAX_VERTICES];
		int kids [MAX_VERTICES];
		report_t r;
		n = live_vertices();
		foreach (seen[i]) begin
			seen[i] = 0;
			has_parent[i] = 0;
			cut[i] = 0;
		end
		clock_t = 0;
		sp = 0;
		seen[0] = 1; disc[0] = 0; lowt[0] = 0; clock_t = 1; kids[0] = 0;
		stk_v[0] = 0; stk_c[0] = adj_head[0]; sp = 1;
		while (sp > 0) begin
			u = stk_v[sp-1];
			lnk = stk_c[sp-1];
			if (lnk != 0 && lnk <= SLOTS) begin
				w = slot_target[lnk-1];
				stk_c[sp-1] = slot_next[lnk-1];
				if (w >= n) continue;
				if (seen[w]) begin
					if (!(has_parent[u] && parent[u] == w) && disc[w] < lowt[u])
						lowt[u] = disc[w];
				end else if (sp < n) begin
					kids[u]++;
					has_parent[w] = 1;
					parent[w] = u;
					seen[w] = 1; disc[w] = clock_t; lowt[w] = clock_t; clock_t++;
					kids[w] = 0;
					stk_v[sp] = w; stk_c[sp] = adj_head[w]; sp++;
				end
			end else begin
				sp--;
				if (!has_parent[u] && kids[u] > 1) cut[u] = 1;
				if (sp > 0) begin
					p = stk_v[sp-1];
					if (lowt[u] < lowt[p]) lowt[p] = lowt[u];
					if (has_parent[p] && lowt[u] >= disc[p]) cut[p] = 1;
				end
			end
		end
		r.sum = '0;
		r.count = '0;
		for (int i = 0; i < n; i++) begin
			if (cut[i]) begin
				r.sum += {{(SUM_BITS-32){vert_weight[i][31]}}, vert_weight[i]};
				r.count++;
			end
		end
		r.positive = (r.sum > 0);
		r.overflow = dropped_edge;
		return r;
	endfunction

	function automatic void apply_item(logic [1:0] f, int a, int b, logic signed [31:0] w);
		int n;
		n = live_vertices();
		case (f)
			FUNC_LOAD: vert_weight[a] = w;
			FUNC_EDGE: begin
				if (a >= n || b >= n || slots_used + 2 > SLOTS) begin
					dropped_edge = 1;
				end else begin
					link_slot(a, b);
					link_slot(b, a);
				end
			end
			FUNC_RUN: pending_reports.insert(pending_reports.size(), predict_cut_report());
			default: ;
		endcase
	endfunction

	task automatic send_item(logic [1:0] f, int a, int b, logic signed [31:0] w);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		vertex_a <= a[7:0];
		vertex_b <= b[7:0];
		weight <= w;
		do @(posedge clk); while (!in_ready);
		apply_item(f, a, b, w);
		items_sent++;
		if (f == FUNC_EDGE) edges_sent++;
		if (f == FUNC_RUN) runs_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_vcount(logic [CNT_BITS-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		vcount_reg = v;
	endtask

	function automatic logic signed [31:0] pick_weight();
		case ($urandom_range(5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $urandom_range(20) - 10;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_load_weights();
		for (int i = 0; i < MAX_VERTICES; i++)
			send_item(FUNC_LOAD, i, $urandom_range(255), pick_weight());
	endtask

	task automatic test_directed();
		// A path makes every inner vertex a cut vertex.
		write_vcount(9'd5);
		send_item(FUNC_LOAD, 2, 0, 32'sh7FFFFFFF);
		send_item(FUNC_LOAD, 3, 0, 32'sh7FFFFFFF);
		send_item(FUNC_LOAD, 1, 0, 32'sh80000000);
		for (int i = 0; i < 4; i++) send_item(FUNC_EDGE, i, i + 1, 0);
		send_item(FUNC_RUN, 0, 0, 0);
		// Self loop, parallel edge and an unused code leave the result alone.
		send_item(FUNC_EDGE, 2, 2, 0);
		send_item(FUNC_EDGE, 3, 2, 0);
		send_item(FUNC_NONE, 8'hFF, 8'hFF, 32'sh7FFFFFFF);
		send_item(FUNC_RUN, 8'hFF, 8'hFF, -1);
		// An endpoint past the vertex count is dropped and raises the flag.
		send_item(FUNC_EDGE, 8'hFF, 1, 0);
		send_item(FUNC_EDGE, 0, 5, 0);
		send_item(FUNC_RUN, 0, 0, 0);
		// Count zero clamps to one; a lowered count hides far neighbors.
		write_vcount(9'd0);
		send_item(FUNC_RUN, 0, 0, 0);
		write_vcount(9'd3);
		send_item(FUNC_RUN, 0, 0, 0);
		write_vcount(9'd511);
		send_item(FUNC_RUN, 0, 0, 0);
		write_vcount(9'd256);
		send_item(FUNC_EDGE, 255, 0, 0);
		send_item(FUNC_RUN, 0, 0, 0);
	endtask

	task automatic test_wait_for_results();
		send_item(FUNC_RUN, 0, 0, 0);
		drain();
		send_item(FUNC_RUN, 0, 0, 0);
	endtask

	task automatic test_random_graphs(int budget);
		int phase, n, k, v;
		phase = 0;
		while (items_sent < budget) begin
			case (phase % 5)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 59; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 59; end
				3: begin idle_pct = 35; stall_pct = 35; end
				default: begin idle_pct = $urandom_range(20); stall_pct = 0; end
			endcase
			case ($urandom_range(9))
				0: n = $urandom_range(1) ? 256 : 511;
				1: n = $urandom_range(1);
				2, 3, 4: n = $urandom_range(8, 2);
				5, 6, 7: n = $urandom_range(40, 9);
				default: n = $urandom_range(255, 41);
			endcase
			write_vcount(n[CNT_BITS-1:0]);
			n = live_vertices();
			k = $urandom_range((n < 24) ? n + 2 : 24);
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(9) == 0) begin
					case ($urandom_range(2))
						0: send_item(FUNC_EDGE, $urandom_range(255), $urandom_range(255), 0);
						1: send_item(FUNC_NONE, $urandom_range(255), $urandom_range(255),
							$urandom);
						default: send_item(FUNC_LOAD, $urandom_range(255),
							$urandom_range(255), pick_weight());
					endcase
				end else if (n > 1) begin
					// Attach to an earlier vertex so the graph stays mostly tree-like.
					v = $urandom_range(n - 1, 1);
					send_item(FUNC_EDGE, $urandom_range(v - 1), v, $urandom);
				end
			end
			send_item(FUNC_RUN, $urandom_range(255), $urandom_range(255), $urandom);
			phase++;
		end
	endtask

	always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		report_t e;
		if (out_valid && out_ready) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected report: sum %0d count %0d",
					weight_sum, cut_count);
			end else begin
				e = pending_reports.pop_front();
				if (weight_sum !== e.sum || is_positive !== e.positive ||
					cut_count !== e.count || edge_overflow !== e.overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("report mismatch: exp sum %0d pos %0b cnt %0d ovf %0b, got sum %0d pos %0b cnt %0d ovf %0b",
							e.sum, e.positive, e.count, e.overflow,
							weight_sum, is_positive, cut_count, edge_overflow);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout with %0d reports outstanding", pending_reports.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		quiet_cycles = 0;
		mismatches = 0;
		reports_seen = 0;
		items_sent = 0;
		edges_sent = 0;
		runs_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		slots_used = 0;
		dropped_edge = 0;
		vcount_reg = 9'd256;
		foreach (adj_head[i]) adj_head[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_weights();
		test_directed();
		test_wait_for_results();
		test_random_graphs(items_sent + 620);
		drain();
		repeat (200) @(posedge clk);
		$display("Covered %0d items: %0d edge adds, %0d walks, %0d reports checked.",
			items_sent, edges_sent, runs_sent, reports_seen);
		$display("Vertex counts from clamped zero to 511, %0d edge slots in use at the end.",
			slots_used);
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("%0d mismatches, %0d reports missing", mismatches,
				pending_reports.size());
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule
